// File: rtl/mwcm_pkg.sv
// Shared constants, types and clamp helpers for the mesh warp coordinate mapper.
package mwcm_pkg;

  localparam int MAX_MESH_SIDE  = 16;
  localparam int MIN_MESH_SIDE  = 2;
  localparam int FRAC_BITS      = 8;
  localparam int MAX_IMAGE_SIDE = 4096;
  localparam int COORD_BIAS     = 8192;

  localparam int SIDE_W   = 5;
  localparam int IMG_W    = 13;
  localparam int PIX_W    = 12;
  localparam int COORD_W  = 14;
  localparam int PT_W     = 2 * COORD_W;
  localparam int IDX_W    = 8;
  localparam int TABLE_DEPTH = 2 ** IDX_W;
  localparam int OUT_W    = 22;
  localparam int UV_W     = 16;
  localparam int SX_W     = PIX_W + SIDE_W;
  localparam int DIV_W    = SX_W + UV_W;
  localparam int BASE_W   = SX_W + SIDE_W + 1;
  localparam int WT_W     = 2 * UV_W + 1;
  localparam int PROD_W   = WT_W + COORD_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int SHIFT    = 2 * UV_W - FRAC_BITS;
  localparam int OUT_LOW  = -2097152;
  localparam int OUT_HIGH = 2096896;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = IMG_W;
  localparam logic [CFG_ADDR_W-1:0] REG_MESH_COLS    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MESH_ROWS    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

  // carried alongside the divider
  typedef struct packed {
    logic             is_map;
    logic [IDX_W-1:0] idx;
    logic [PT_W-1:0]  pt;     // {y, x}
  } item_t;

  // queue entry from the front end
  typedef struct packed {
    item_t           item;
    logic [SX_W-1:0] sx;
    logic [SX_W-1:0] sy;
  } entry_t;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = v;
    if (int'(v) < MIN_MESH_SIDE) r = SIDE_W'(MIN_MESH_SIDE);
    else if (int'(v) > MAX_MESH_SIDE) r = SIDE_W'(MAX_MESH_SIDE);
    return r;
  endfunction

  function automatic logic [IMG_W-1:0] clamp_img(input logic [IMG_W-1:0] v);
    logic [IMG_W-1:0] r;
    r = v;
    if (v == '0) r = IMG_W'(1);
    else if (int'(v) > MAX_IMAGE_SIDE) r = IMG_W'(MAX_IMAGE_SIDE);
    return r;
  endfunction

endpackage

// File: rtl/mwcm_front.sv
// Front end: classifies an input item and, for map items, scales the pixel position by the mesh size less one.
module mwcm_front import mwcm_pkg::*; (
  input  logic               mode,
  input  logic [IDX_W-1:0]   point_index,
  input  logic [COORD_W-1:0] point_x,
  input  logic [COORD_W-1:0] point_y,
  input  logic [PIX_W-1:0]   pixel_x,
  input  logic [PIX_W-1:0]   pixel_y,
  input  logic [SIDE_W-1:0]  mesh_cols,
  input  logic [SIDE_W-1:0]  mesh_rows,
  output entry_t             entry
);

  logic [SIDE_W-1:0] cols_m1;
  logic [SIDE_W-1:0] rows_m1;

  assign cols_m1 = clamp_side(mesh_cols) - SIDE_W'(1);
  assign rows_m1 = clamp_side(mesh_rows) - SIDE_W'(1);

  always_comb begin
    entry.item.is_map = mode;
    entry.item.idx    = point_index;
    entry.item.pt     = {point_y, point_x};
    entry.sx = mode ? SX_W'(SX_W'(pixel_x) * SX_W'(cols_m1)) : '0;
    entry.sy = mode ? SX_W'(SX_W'(pixel_y) * SX_W'(rows_m1)) : '0;
  end

endmodule

// File: rtl/mwcm_queue.sv
// Short queue between the front end and the mapping pipeline.
module mwcm_queue import mwcm_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  output logic   not_full,
  input  logic   pop,
  output logic   not_empty,
  output entry_t pop_data
);

  entry_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head_r;
  logic [QPTR_W-1:0] tail_r;
  logic [QPTR_W:0]   count_r;

  assign not_full  = (count_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = slot_r[head_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[tail_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) tail_r <= tail_r + QPTR_W'(1);
      if (pop)  head_r <= head_r + QPTR_W'(1);
      if (push && !pop)      count_r <= count_r + (QPTR_W+1)'(1);
      else if (!push && pop) count_r <= count_r - (QPTR_W+1)'(1);
    end
  end

endmodule

// File: rtl/mwcm_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module mwcm_div import mwcm_pkg::*; #(
  parameter int ND = DIV_W,
  parameter int DW = IMG_W
) (
  input  logic          clk,
  input  logic          en,
  input  logic [ND-1:0] num,
  input  logic [DW-1:0] den,
  output logic [ND-1:0] quo
);

  logic [DW-1:0] rem_r [ND];
  logic [ND-1:0] num_r [ND];
  logic [ND-1:0] q_r   [ND];

  genvar s;
  generate
    for (s = 0; s < ND; s++) begin : g_stage
      logic [DW-1:0] rem_i;
      logic [ND-1:0] num_i;
      logic [ND-1:0] q_i;
      logic [DW:0]   trial;
      logic          ge;

      if (s == 0) begin : g_first
        assign rem_i = '0;
        assign num_i = num;
        assign q_i   = '0;
      end else begin : g_next
        assign rem_i = rem_r[s-1];
        assign num_i = num_r[s-1];
        assign q_i   = q_r[s-1];
      end

      assign trial = {rem_i, num_i[ND-1]};
      assign ge    = (trial >= {1'b0, den});

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= ge ? DW'(trial - {1'b0, den}) : DW'(trial);
          num_r[s] <= num_i << 1;
          q_r[s]   <= {q_i[ND-2:0], ge};
        end
      end
    end
  endgenerate

  assign quo = q_r[ND-1];

endmodule

// File: rtl/mwcm_back.sv
// Mapping pipeline: cell division, corner lookup, bilinear blend and output register.
module mwcm_back import mwcm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SIDE_W-1:0] mesh_cols,
  input  logic [SIDE_W-1:0] mesh_rows,
  input  logic [IMG_W-1:0]  image_width,
  input  logic [IMG_W-1:0]  image_height,
  input  logic              head_valid,
  input  entry_t            head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_W-1:0]  source_x,
  output logic [OUT_W-1:0]  source_y,
  output logic              in_bounds
);

  localparam logic [ACC_W:0] BIAS_FIX = (ACC_W+1)'(COORD_BIAS * (2 ** FRAC_BITS));
  localparam logic signed [ACC_W:0] LOW_S  = (ACC_W+1)'(OUT_LOW);
  localparam logic signed [ACC_W:0] HIGH_S = (ACC_W+1)'(OUT_HIGH);

  logic              adv;
  logic [SIDE_W-1:0] cols;
  logic [SIDE_W-1:0] rows;
  logic [IMG_W-1:0]  w_c;
  logic [IMG_W-1:0]  h_c;

  assign cols = clamp_side(mesh_cols);
  assign rows = clamp_side(mesh_rows);
  assign w_c  = clamp_img(image_width);
  assign h_c  = clamp_img(image_height);

  logic out_valid_r;
  assign adv       = !out_valid_r || out_ready;
  assign pop       = adv && head_valid;
  assign out_valid = out_valid_r;

  // divider stages with the item riding alongside
  logic [DIV_W-1:0] qx;
  logic [DIV_W-1:0] qy;
  logic             dv_r [DIV_W];
  item_t            dit_r [DIV_W];

  mwcm_div #(.ND(DIV_W), .DW(IMG_W)) u_div_x (
    .clk(clk), .en(adv), .num({head.sx, UV_W'(0)}), .den(w_c), .quo(qx)
  );
  mwcm_div #(.ND(DIV_W), .DW(IMG_W)) u_div_y (
    .clk(clk), .en(adv), .num({head.sy, UV_W'(0)}), .den(h_c), .quo(qy)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dit_r[0] <= head.item;
      for (int i = 1; i < DIV_W; i++) dit_r[i] <= dit_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_W; i++) dv_r[i] <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= head_valid;
      for (int i = 1; i < DIV_W; i++) dv_r[i] <= dv_r[i-1];
    end
  end

  // stage A: cell base index and fractions
  logic              a_v_r;
  item_t             a_it_r;
  logic [BASE_W-1:0] a_base_r;
  logic [UV_W-1:0]   a_uf_r;
  logic [UV_W-1:0]   a_vf_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_it_r   <= dit_r[DIV_W-1];
      a_base_r <= BASE_W'(qy[DIV_W-1:UV_W]) * BASE_W'(cols) + BASE_W'(qx[DIV_W-1:UV_W]);
      a_uf_r   <= qx[UV_W-1:0];
      a_vf_r   <= qy[UV_W-1:0];
    end
  end

  // stage B: corner indices, table access, weights
  logic [2*SIDE_W-1:0] last_full;
  logic [IDX_W-1:0]    last_c;
  logic [BASE_W-1:0]   corner [4];
  logic [IDX_W-1:0]    ridx [4];
  logic [UV_W:0]       om_u;
  logic [UV_W:0]       om_v;

  assign last_full = (2*SIDE_W)'(cols) * (2*SIDE_W)'(rows) - (2*SIDE_W)'(1);
  assign last_c = (last_full > (2*SIDE_W)'(TABLE_DEPTH - 1)) ?
                  IDX_W'(TABLE_DEPTH - 1) : IDX_W'(last_full);
  assign corner[0] = a_base_r;
  assign corner[1] = a_base_r + BASE_W'(1);
  assign corner[2] = a_base_r + BASE_W'(cols);
  assign corner[3] = a_base_r + BASE_W'(cols) + BASE_W'(1);
  assign om_u = (UV_W+1)'(2 ** UV_W) - (UV_W+1)'(a_uf_r);
  assign om_v = (UV_W+1)'(2 ** UV_W) - (UV_W+1)'(a_vf_r);

  logic            b_v_r;
  logic            b_map_r;
  logic [WT_W-1:0] b_wt_r [4];
  logic [PT_W-1:0] b_rd_r [4];

  genvar k;
  generate
    for (k = 0; k < 4; k++) begin : g_copy
      logic [PT_W-1:0] mem [TABLE_DEPTH];
      assign ridx[k] = (corner[k] > BASE_W'(last_c)) ? last_c : IDX_W'(corner[k]);
      // every copy takes each load; each serves one corner
      always_ff @(posedge clk) begin
        if (adv) begin
          if (a_v_r && !a_it_r.is_map) mem[a_it_r.idx] <= a_it_r.pt;
          b_rd_r[k] <= mem[ridx[k]];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (adv) begin
      b_map_r   <= a_it_r.is_map;
      b_wt_r[0] <= WT_W'(om_u) * WT_W'(om_v);
      b_wt_r[1] <= WT_W'(a_uf_r) * WT_W'(om_v);
      b_wt_r[2] <= WT_W'(om_u) * WT_W'(a_vf_r);
      b_wt_r[3] <= WT_W'(a_uf_r) * WT_W'(a_vf_r);
    end
  end

  // stage C: weighted corners, coordinates biased to unsigned by flipping the sign bit
  logic              c_v_r;
  logic              c_map_r;
  logic [PROD_W-1:0] c_px_r [4];
  logic [PROD_W-1:0] c_py_r [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      c_map_r <= b_map_r;
      for (int i = 0; i < 4; i++) begin
        c_px_r[i] <= PROD_W'(b_wt_r[i]) *
                     PROD_W'({~b_rd_r[i][COORD_W-1], b_rd_r[i][COORD_W-2:0]});
        c_py_r[i] <= PROD_W'(b_wt_r[i]) *
                     PROD_W'({~b_rd_r[i][PT_W-1], b_rd_r[i][PT_W-2:COORD_W]});
      end
    end
  end

  // stage D: sums
  logic             d_v_r;
  logic             d_map_r;
  logic [ACC_W-1:0] d_ax_r;
  logic [ACC_W-1:0] d_ay_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      d_map_r <= c_map_r;
      d_ax_r  <= ACC_W'(c_px_r[0]) + ACC_W'(c_px_r[1]) + ACC_W'(c_px_r[2]) + ACC_W'(c_px_r[3]);
      d_ay_r  <= ACC_W'(c_py_r[0]) + ACC_W'(c_py_r[1]) + ACC_W'(c_py_r[2]) + ACC_W'(c_py_r[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= dv_r[DIV_W-1];
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
    end
  end

  // stage E: floor shift, unbias, saturate, bounds
  logic signed [ACC_W:0] rx;
  logic signed [ACC_W:0] ry;
  logic signed [ACC_W:0] wlim;
  logic signed [ACC_W:0] hlim;
  logic signed [ACC_W:0] rx_sat;
  logic signed [ACC_W:0] ry_sat;

  assign rx   = $signed({1'b0, d_ax_r >> SHIFT} - BIAS_FIX);
  assign ry   = $signed({1'b0, d_ay_r >> SHIFT} - BIAS_FIX);
  assign wlim = $signed((ACC_W+1)'(w_c) << FRAC_BITS);
  assign hlim = $signed((ACC_W+1)'(h_c) << FRAC_BITS);
  assign rx_sat = (rx < LOW_S) ? LOW_S : ((rx > HIGH_S) ? HIGH_S : rx);
  assign ry_sat = (ry < LOW_S) ? LOW_S : ((ry > HIGH_S) ? HIGH_S : ry);

  logic [OUT_W-1:0] sx_r;
  logic [OUT_W-1:0] sy_r;
  logic             inb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sx_r  <= rx_sat[OUT_W-1:0];
      sy_r  <= ry_sat[OUT_W-1:0];
      inb_r <= (rx >= 0) && (rx < wlim) && (ry >= 0) && (ry < hlim);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= d_v_r && d_map_r;
  end

  assign source_x  = sx_r;
  assign source_y  = sy_r;
  assign in_bounds = inb_r;

endmodule

// File: rtl/mesh_warp_coordinate_mapper_top.sv
// Top level of the mesh warp coordinate mapper: config registers, front end, queue, pipeline.
// Takes one item per clock while the queue has room and returns one mapped source coordinate
// per map item, in order, through a queue register, a 33-stage one-bit-per-stage divider for
// the cell position, then index, table read, multiply, sum and output stages. Load items write
// a mesh point and produce no result; a later map item always sees every earlier load. The
// point table is not cleared at reset: a map item must only touch points already loaded. The
// block stalls as a whole while the output transfer is held off; the queue keeps the input side
// taking items until its four slots are full.
module mesh_warp_coordinate_mapper_top import mwcm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [63:0]           in_tdata,   // point_index, point_x, point_y, pixel_x, pixel_y, pad
  input  logic                  in_tuser,   // mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,  // source_x, source_y, pad
  output logic                  out_tuser   // in_bounds
);

  logic [SIDE_W-1:0] mesh_cols_r;
  logic [SIDE_W-1:0] mesh_rows_r;
  logic [IMG_W-1:0]  image_width_r;
  logic [IMG_W-1:0]  image_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mesh_cols_r    <= SIDE_W'(2);
      mesh_rows_r    <= SIDE_W'(2);
      image_width_r  <= IMG_W'(640);
      image_height_r <= IMG_W'(480);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MESH_COLS:    mesh_cols_r    <= cfg_wdata[SIDE_W-1:0];
        REG_MESH_ROWS:    mesh_rows_r    <= cfg_wdata[SIDE_W-1:0];
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[IMG_W-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[IMG_W-1:0];
      endcase
    end
  end

  entry_t           fe_entry;
  entry_t           q_head;
  logic             q_not_full;
  logic             q_not_empty;
  logic             q_pop;
  logic [OUT_W-1:0] src_x;
  logic [OUT_W-1:0] src_y;

  mwcm_front u_front (
    .mode        (in_tuser),
    .point_index (in_tdata[7:0]),
    .point_x     (in_tdata[21:8]),
    .point_y     (in_tdata[35:22]),
    .pixel_x     (in_tdata[47:36]),
    .pixel_y     (in_tdata[59:48]),
    .mesh_cols   (mesh_cols_r),
    .mesh_rows   (mesh_rows_r),
    .entry       (fe_entry)
  );

  assign in_tready = q_not_full;

  mwcm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid && q_not_full),
    .push_data (fe_entry),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_head)
  );

  mwcm_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .mesh_cols    (mesh_cols_r),
    .mesh_rows    (mesh_rows_r),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .head_valid   (q_not_empty),
    .head         (q_head),
    .pop          (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .source_x     (src_x),
    .source_y     (src_y),
    .in_bounds    (out_tuser)
  );

  assign out_tdata = {4'b0, src_y, src_x};

endmodule
